// ===== hw/rtl/iate_pkg.sv =====
// Package for the indexed array table engine: sizes, codes and beat structs.
// No dependencies.
package iate_pkg;
	localparam int Depth = 256;
	localparam int AddrW = 8;
	localparam int CountW = 9;

	typedef enum logic [3:0] {
		ACT_PUSH    = 4'd0,
		ACT_INSERT  = 4'd1,
		ACT_GET     = 4'd2,
		ACT_SET     = 4'd3,
		ACT_REMOVE  = 4'd4,
		ACT_FIND    = 4'd5,
		ACT_BSEARCH = 4'd6,
		ACT_SORT    = 4'd7,
		ACT_CLEAR   = 4'd8,
		ACT_RESIZE  = 4'd9
	} action_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [3:0]         action;
		logic [CountW-1:0]  position;
		logic signed [63:0] operand;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] read_value;
		logic [AddrW-1:0]   found_at;
		logic [CountW-1:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] waddr;
		logic [63:0]      wdata;
		logic [AddrW-1:0] raddr;
	} mem_ctl_t;
endpackage

// ===== hw/rtl/iate_store.sv =====
// Entry store: 256 x 64-bit memory, one write and one registered read port.
// Depends on iate_pkg.
module iate_store (
	input  logic              clk,
	input  iate_pkg::mem_ctl_t ctl,
	output logic [63:0]       rdata
);
	import iate_pkg::*;

	logic [63:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end
endmodule

// ===== hw/rtl/indexed_array_table_engine_unit.sv =====
// Indexed array table engine: sequencer over one 256 x 64-bit store and one shared
// signed 64-bit comparator. Depends on iate_pkg and iate_store.
// Push, set, clear, resize and unused codes go from decode straight to done; get reads
// one entry, growth writes each new entry, insert, remove and find walk one entry per step,
// bsearch halves the range per step, and sort walks each entry and shifts it into place.
// Busy is high from decode through the done cycle; reset clears the count, not the store.
module indexed_array_table_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  iate_pkg::req_t    req,
	output logic              busy,
	output logic              done,
	output iate_pkg::rsp_t    rsp
);
	import iate_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DEC   = 10'b0000000010,
		S_RD    = 10'b0000000100,
		S_WAIT  = 10'b0000001000,
		S_USE   = 10'b0000010000,
		S_FILL  = 10'b0000100000,
		S_SORTI = 10'b0001000000,
		S_SORTW = 10'b0010000000,
		S_SORTC = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CountW-1:0] count_q, idx_q, lo_q, hi_q, mid_q, outer_q;
	logic [63:0] key_q;
	logic [1:0] status_q;
	logic [63:0] rdv_q;
	logic [AddrW-1:0] at_q;
	mem_ctl_t ctl;
	logic [63:0] rdata;
	logic lt, eq;

	iate_store u_store (.clk(clk), .ctl(ctl), .rdata(rdata));

	// Shared comparator: key against the entry read back.
	assign eq = (key_q == rdata);
	assign lt = ($signed(key_q) < $signed(rdata));

	logic [CountW:0] sum;
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_RD, S_WAIT: begin
				unique case (req_q.action)
					ACT_GET: ctl.raddr = AddrW'(req_q.position);
					ACT_INSERT: ctl.raddr = AddrW'(idx_q - 1'b1);
					ACT_REMOVE: ctl.raddr = AddrW'(idx_q + 1'b1);
					ACT_BSEARCH: ctl.raddr = AddrW'(sum[CountW:1]);
					default: ctl.raddr = AddrW'(idx_q);
				endcase
			end
			S_USE: begin
				unique case (req_q.action)
					ACT_INSERT: begin
						ctl.we = 1'b1;
						ctl.waddr = AddrW'(idx_q);
						ctl.wdata = (idx_q == req_q.position) ? req_q.operand : rdata;
					end
					ACT_REMOVE: begin
						ctl.we = 1'b1;
						ctl.waddr = AddrW'(idx_q);
						ctl.wdata = rdata;
					end
					default: ;
				endcase
			end
			S_DEC: begin
				ctl.raddr = AddrW'(req_q.position);
				unique case (req_q.action)
					ACT_PUSH: begin
						ctl.we = (count_q < CountW'(Depth));
						ctl.waddr = AddrW'(count_q);
						ctl.wdata = req_q.operand;
					end
					ACT_SET: begin
						ctl.we = (req_q.position < count_q);
						ctl.waddr = AddrW'(req_q.position);
						ctl.wdata = req_q.operand;
					end
					default: ;
				endcase
			end
			S_FILL: begin
				ctl.we = 1'b1;
				ctl.waddr = AddrW'(idx_q);
			end
			S_SORTI: ctl.raddr = AddrW'(outer_q);
			S_SORTW: ctl.raddr = AddrW'(idx_q - 1'b1);
			S_SORTC: begin
				ctl.we = 1'b1;
				ctl.waddr = AddrW'(idx_q);
				if (idx_q != '0 && lt) begin
					ctl.wdata = rdata;
					ctl.raddr = AddrW'(idx_q - 2'd2);
				end else begin
					ctl.wdata = key_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			status_q <= ST_OK;
			rdv_q <= '0;
			at_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						key_q <= req.operand;
						status_q <= ST_OK;
						rdv_q <= '0;
						at_q <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_DONE;
					unique case (req_q.action)
						ACT_PUSH: begin
							if (count_q >= CountW'(Depth)) status_q <= ST_FULL;
							else count_q <= count_q + 1'b1;
						end
						ACT_INSERT: begin
							if (req_q.position > count_q) status_q <= ST_RANGE;
							else if (count_q >= CountW'(Depth)) status_q <= ST_FULL;
							else begin
								idx_q <= count_q;
								state_q <= S_RD;
							end
						end
						ACT_GET: begin
							if (req_q.position >= count_q) status_q <= ST_RANGE;
							else state_q <= S_WAIT;
						end
						ACT_SET: begin
							if (req_q.position >= count_q) status_q <= ST_RANGE;
						end
						ACT_REMOVE: begin
							if (req_q.position >= count_q) status_q <= ST_RANGE;
							else begin
								idx_q <= req_q.position;
								state_q <= S_RD;
							end
						end
						ACT_FIND: begin
							status_q <= ST_MISSING;
							idx_q <= '0;
							if (count_q != '0) state_q <= S_RD;
						end
						ACT_BSEARCH: begin
							status_q <= ST_MISSING;
							lo_q <= '0;
							hi_q <= count_q;
							if (count_q != '0) state_q <= S_RD;
						end
						ACT_SORT: begin
							outer_q <= CountW'(1);
							if (count_q > CountW'(1)) begin
								idx_q <= CountW'(1);
								state_q <= S_SORTI;
							end
						end
						ACT_CLEAR: count_q <= '0;
						ACT_RESIZE: begin
							if (req_q.position > CountW'(Depth)) status_q <= ST_FULL;
							else if (req_q.position > count_q) begin
								idx_q <= count_q;
								state_q <= S_FILL;
							end else count_q <= req_q.position;
						end
						default: ;
					endcase
				end
				S_RD: begin
					if (req_q.action == ACT_INSERT && idx_q == req_q.position)
						state_q <= S_USE;
					else if (req_q.action == ACT_REMOVE && idx_q + 1'b1 >= count_q)
						state_q <= S_USE;
					else begin
						mid_q <= sum[CountW:1];
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_USE;
				S_USE: begin
					state_q <= S_RD;
					unique case (req_q.action)
						ACT_GET: begin
							rdv_q <= rdata;
							state_q <= S_DONE;
						end
						ACT_INSERT: begin
							idx_q <= idx_q - 1'b1;
							if (idx_q == req_q.position) begin
								count_q <= count_q + 1'b1;
								state_q <= S_DONE;
							end
						end
						ACT_REMOVE: begin
							idx_q <= idx_q + 1'b1;
							if (idx_q + 1'b1 >= count_q) begin
								count_q <= count_q - 1'b1;
								state_q <= S_DONE;
							end
						end
						ACT_FIND: begin
							if (eq) begin
								status_q <= ST_OK;
								at_q <= AddrW'(idx_q);
								state_q <= S_DONE;
							end else if (idx_q + 1'b1 >= count_q) state_q <= S_DONE;
							idx_q <= idx_q + 1'b1;
						end
						ACT_BSEARCH: begin
							if (eq) begin
								status_q <= ST_OK;
								at_q <= AddrW'(mid_q);
								state_q <= S_DONE;
							end else if (lt) begin
								hi_q <= mid_q;
								if (lo_q >= mid_q) state_q <= S_DONE;
							end else begin
								lo_q <= mid_q + 1'b1;
								if (mid_q + 1'b1 >= hi_q) state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FILL: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 >= req_q.position) begin
						count_q <= req_q.position;
						state_q <= S_DONE;
					end
				end
				S_SORTI: state_q <= S_SORTW;
				S_SORTW: begin
					// The entry at the outer index becomes the key for this pass.
					key_q <= rdata;
					state_q <= S_SORTC;
				end
				S_SORTC: begin
					if (idx_q != '0 && lt) begin
						idx_q <= idx_q - 1'b1;
					end else if (outer_q + 1'b1 >= count_q) begin
						state_q <= S_DONE;
					end else begin
						outer_q <= outer_q + 1'b1;
						idx_q <= outer_q + 1'b1;
						state_q <= S_SORTI;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp.status = status_q;
		rsp.read_value = rdv_q;
		rsp.found_at = at_q;
		rsp.entry_count = count_q;
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Depth)) else $error("count exceeds depth");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
endmodule
